/* rtl/mdd_pkg.sv */
// ----------------------------------------------------------------------------
// mdd_pkg
// Shared widths, types and constants for the drop-one Manhattan diameter block.
// ----------------------------------------------------------------------------
`default_nettype none

package mdd_pkg;

    localparam int COORD_BITS  = 27;
    localparam int MAX_POINTS  = 65536;

    localparam int SUM_BITS    = COORD_BITS + 2;
    localparam int DIFF_BITS   = COORD_BITS + 1;
    localparam int DIST_BITS   = COORD_BITS + 1;
    localparam int SPREAD_BITS = COORD_BITS + 3;
    localparam int COUNT_BITS  = $clog2(MAX_POINTS + 1);
    localparam int INDEX_BITS  = $clog2(MAX_POINTS);
    localparam int HOLDERS     = 4;

    // Slots of the extreme holder table
    localparam int HOLD_SMAX = 0;
    localparam int HOLD_SMIN = 1;
    localparam int HOLD_DMAX = 2;
    localparam int HOLD_DMIN = 3;

    typedef logic        [COORD_BITS-1:0]  coord_t;
    typedef logic        [SUM_BITS-1:0]    sum_t;
    typedef logic signed [DIFF_BITS-1:0]   diff_t;
    typedef logic        [DIST_BITS-1:0]   dist_t;
    typedef logic signed [SPREAD_BITS-1:0] spread_t;
    typedef logic        [COUNT_BITS-1:0]  count_t;
    typedef logic        [INDEX_BITS-1:0]  index_t;

    localparam sum_t  SUM_MAX_INIT  = '0;
    localparam sum_t  SUM_MIN_INIT  = '1;
    localparam diff_t DIFF_MAX_INIT = {1'b1, {(DIFF_BITS-1){1'b0}}};
    localparam diff_t DIFF_MIN_INIT = {1'b0, {(DIFF_BITS-1){1'b1}}};

    // Extremes of a finished set, handed from the tracker to the selector
    typedef struct packed {
        logic                             valid;
        logic                             overflow;
        logic                             enough;
        sum_t                             smax1;
        sum_t                             smax2;
        sum_t                             smin1;
        sum_t                             smin2;
        diff_t                            dmax1;
        diff_t                            dmax2;
        diff_t                            dmin1;
        diff_t                            dmin2;
        logic [HOLDERS-1:0][INDEX_BITS-1:0] holder;
    } snap_t;

endpackage

`default_nettype wire

/* rtl/mdd_if.sv */
// ----------------------------------------------------------------------------
// mdd_if
// Valid/ready channels: point input and distance result.
// ----------------------------------------------------------------------------
`default_nettype none

interface mdd_point_if;
    logic                         valid;
    logic                         ready;
    logic [mdd_pkg::COORD_BITS-1:0] x_coord;
    logic [mdd_pkg::COORD_BITS-1:0] y_coord;
    logic                         last_point;

    modport source (output valid, output x_coord, output y_coord, output last_point,
                    input ready);
    modport sink   (input valid, input x_coord, input y_coord, input last_point,
                    output ready);
endinterface

interface mdd_result_if;
    logic                        valid;
    logic                        ready;
    logic [mdd_pkg::DIST_BITS-1:0] best_distance;
    logic                        count_clipped;

    modport source (output valid, output best_distance, output count_clipped,
                    input ready);
    modport sink   (input valid, input best_distance, input count_clipped,
                    output ready);
endinterface

`default_nettype wire

/* rtl/mdd_tracker.sv */
// ----------------------------------------------------------------------------
// mdd_tracker
// Input register, running first/second extremes of s=x+y and d=x-y with
// holder indexes, and the end-of-set snapshot register.
// ----------------------------------------------------------------------------
`default_nettype none

module mdd_tracker (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             advance,
    input  wire logic             in_valid,
    input  wire mdd_pkg::coord_t  x_coord,
    input  wire mdd_pkg::coord_t  y_coord,
    input  wire logic             last_point,
    output mdd_pkg::snap_t        snap
);
    import mdd_pkg::*;

    logic   a_valid_reg;
    coord_t a_x_reg;
    coord_t a_y_reg;
    logic   a_last_reg;

    count_t count_reg,  count_next;
    sum_t   smax1_reg,  smax1_next;
    sum_t   smax2_reg,  smax2_next;
    sum_t   smin1_reg,  smin1_next;
    sum_t   smin2_reg,  smin2_next;
    diff_t  dmax1_reg,  dmax1_next;
    diff_t  dmax2_reg,  dmax2_next;
    diff_t  dmin1_reg,  dmin1_next;
    diff_t  dmin2_reg,  dmin2_next;
    logic [HOLDERS-1:0][INDEX_BITS-1:0] holder_reg, holder_next;
    logic   ovf_reg,    ovf_next;

    logic   snap_valid_reg;
    snap_t  snap_reg;

    sum_t   s_val;
    diff_t  d_val;
    index_t idx;
    logic   clipped;
    logic   finish;

    assign finish = a_valid_reg & a_last_reg;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            a_x_reg    <= x_coord;
            a_y_reg    <= y_coord;
            a_last_reg <= last_point;
        end
    end

    // Compare-and-replace; ties go to the second slot
    always_comb
    begin
        s_val   = SUM_BITS'(a_x_reg) + SUM_BITS'(a_y_reg);
        d_val   = $signed(DIFF_BITS'(a_x_reg)) - $signed(DIFF_BITS'(a_y_reg));
        idx     = count_reg[INDEX_BITS-1:0];
        clipped = (count_reg >= COUNT_BITS'(MAX_POINTS));

        count_next  = count_reg;
        smax1_next  = smax1_reg;
        smax2_next  = smax2_reg;
        smin1_next  = smin1_reg;
        smin2_next  = smin2_reg;
        dmax1_next  = dmax1_reg;
        dmax2_next  = dmax2_reg;
        dmin1_next  = dmin1_reg;
        dmin2_next  = dmin2_reg;
        holder_next = holder_reg;
        ovf_next    = ovf_reg;

        if (clipped)
        begin
            ovf_next = 1'b1;
        end
        else
        begin
            count_next = count_reg + 1'b1;

            if (s_val > smax1_reg)
            begin
                smax2_next            = smax1_reg;
                smax1_next            = s_val;
                holder_next[HOLD_SMAX] = idx;
            end
            else if (s_val > smax2_reg)
            begin
                smax2_next = s_val;
            end

            if (s_val < smin1_reg)
            begin
                smin2_next            = smin1_reg;
                smin1_next            = s_val;
                holder_next[HOLD_SMIN] = idx;
            end
            else if (s_val < smin2_reg)
            begin
                smin2_next = s_val;
            end

            if (d_val > dmax1_reg)
            begin
                dmax2_next            = dmax1_reg;
                dmax1_next            = d_val;
                holder_next[HOLD_DMAX] = idx;
            end
            else if (d_val > dmax2_reg)
            begin
                dmax2_next = d_val;
            end

            if (d_val < dmin1_reg)
            begin
                dmin2_next            = dmin1_reg;
                dmin1_next            = d_val;
                holder_next[HOLD_DMIN] = idx;
            end
            else if (d_val < dmin2_reg)
            begin
                dmin2_next = d_val;
            end
        end
    end

    // Running state; cleared after the last point of a set
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            smax1_reg  <= SUM_MAX_INIT;
            smax2_reg  <= SUM_MAX_INIT;
            smin1_reg  <= SUM_MIN_INIT;
            smin2_reg  <= SUM_MIN_INIT;
            dmax1_reg  <= DIFF_MAX_INIT;
            dmax2_reg  <= DIFF_MAX_INIT;
            dmin1_reg  <= DIFF_MIN_INIT;
            dmin2_reg  <= DIFF_MIN_INIT;
            holder_reg <= '0;
            ovf_reg    <= 1'b0;
        end
        else if (advance && a_valid_reg)
        begin
            if (a_last_reg)
            begin
                count_reg  <= '0;
                smax1_reg  <= SUM_MAX_INIT;
                smax2_reg  <= SUM_MAX_INIT;
                smin1_reg  <= SUM_MIN_INIT;
                smin2_reg  <= SUM_MIN_INIT;
                dmax1_reg  <= DIFF_MAX_INIT;
                dmax2_reg  <= DIFF_MAX_INIT;
                dmin1_reg  <= DIFF_MIN_INIT;
                dmin2_reg  <= DIFF_MIN_INIT;
                holder_reg <= '0;
                ovf_reg    <= 1'b0;
            end
            else
            begin
                count_reg  <= count_next;
                smax1_reg  <= smax1_next;
                smax2_reg  <= smax2_next;
                smin1_reg  <= smin1_next;
                smin2_reg  <= smin2_next;
                dmax1_reg  <= dmax1_next;
                dmax2_reg  <= dmax2_next;
                dmin1_reg  <= dmin1_next;
                dmin2_reg  <= dmin2_next;
                holder_reg <= holder_next;
                ovf_reg    <= ovf_next;
            end
        end
    end

    // Snapshot of the finished set
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            snap_valid_reg <= finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && finish)
        begin
            snap_reg.valid    <= 1'b1;
            snap_reg.overflow <= ovf_next;
            snap_reg.enough   <= (count_next > COUNT_BITS'(2));
            snap_reg.smax1    <= smax1_next;
            snap_reg.smax2    <= smax2_next;
            snap_reg.smin1    <= smin1_next;
            snap_reg.smin2    <= smin2_next;
            snap_reg.dmax1    <= dmax1_next;
            snap_reg.dmax2    <= dmax2_next;
            snap_reg.dmin1    <= dmin1_next;
            snap_reg.dmin2    <= dmin2_next;
            snap_reg.holder   <= holder_next;
        end
    end

    always_comb
    begin
        snap       = snap_reg;
        snap.valid = snap_valid_reg;
    end

endmodule

`default_nettype wire

/* rtl/mdd_select.sv */
// ----------------------------------------------------------------------------
// mdd_select
// Tries dropping each of the four extreme holders, keeps the smallest
// spread, and holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mdd_select (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire mdd_pkg::snap_t snap,
    input  wire logic           out_ready,
    output logic                out_valid,
    output mdd_pkg::dist_t      best_distance,
    output logic                count_clipped,
    output logic                advance
);
    import mdd_pkg::*;

    logic    out_valid_reg;
    dist_t   best_reg;
    logic    clip_reg;

    spread_t cand [HOLDERS];
    spread_t best;
    dist_t   best_dist;

    function automatic spread_t spread_without(snap_t sn, index_t drop);
        sum_t    smax;
        sum_t    smin;
        diff_t   dmax;
        diff_t   dmin;
        spread_t rs;
        spread_t rd;
        smax = (sn.holder[HOLD_SMAX] == drop) ? sn.smax2 : sn.smax1;
        smin = (sn.holder[HOLD_SMIN] == drop) ? sn.smin2 : sn.smin1;
        dmax = (sn.holder[HOLD_DMAX] == drop) ? sn.dmax2 : sn.dmax1;
        dmin = (sn.holder[HOLD_DMIN] == drop) ? sn.dmin2 : sn.dmin1;
        rs   = $signed({1'b0, smax}) - $signed({1'b0, smin});
        rd   = SPREAD_BITS'(dmax) - SPREAD_BITS'(dmin);
        return (rs > rd) ? rs : rd;
    endfunction

    assign advance = !out_valid_reg || out_ready;

    always_comb
    begin
        for (int k = 0; k < HOLDERS; k++)
        begin
            cand[k] = spread_without(snap, snap.holder[k]);
        end
        best = cand[0];
        for (int k = 1; k < HOLDERS; k++)
        begin
            if (cand[k] < best)
            begin
                best = cand[k];
            end
        end
        if (!snap.enough || best < 0)
        begin
            best_dist = '0;
        end
        else
        begin
            best_dist = best[DIST_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= snap.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && snap.valid)
        begin
            best_reg <= best_dist;
            clip_reg <= snap.overflow;
        end
    end

    assign out_valid     = out_valid_reg;
    assign best_distance = best_reg;
    assign count_clipped = clip_reg;

endmodule

`default_nettype wire

/* rtl/manhattan_diameter_drop_one_core.sv */
// ----------------------------------------------------------------------------
// manhattan_diameter_drop_one_core
// Smallest largest Manhattan distance of a point set after removing one point.
//
// point_in carries one point per transaction (x_coord, y_coord, last_point).
// Points of a set are streamed in order; last_point closes the set. For each
// closed set exactly one transaction leaves on result_out with best_distance
// and count_clipped (points beyond the capacity were dropped). Sets of two or
// fewer points give 0. Points that do not close a set produce nothing.
// Throughput: one point per cycle, sustained, as long as result_out is taken.
// The last point of a set passes the input register, then the
// extremes/snapshot register, then the output register. All three stages
// move together; when result_out holds a result and ready is low,
// point_in.ready drops and everything holds.
// Reset clears all running extremes, counts and valid flags; the block is
// ready once reset is released.
// ----------------------------------------------------------------------------
`default_nettype none

module manhattan_diameter_drop_one_core (
    input  wire logic    clk,
    input  wire logic    rst_n,
    mdd_point_if.sink    point_in,
    mdd_result_if.source result_out
);
    import mdd_pkg::*;

    snap_t snap;
    logic  advance;

    assign point_in.ready = advance;

    mdd_tracker u_tracker (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .in_valid   (point_in.valid),
        .x_coord    (point_in.x_coord),
        .y_coord    (point_in.y_coord),
        .last_point (point_in.last_point),
        .snap       (snap)
    );

    mdd_select u_select (
        .clk           (clk),
        .rst_n         (rst_n),
        .snap          (snap),
        .out_ready     (result_out.ready),
        .out_valid     (result_out.valid),
        .best_distance (result_out.best_distance),
        .count_clipped (result_out.count_clipped),
        .advance       (advance)
    );

endmodule

`default_nettype wire
